// File: rtl/eased_transition_interpolator_macros.svh
// assertion macros shared by the checker
`ifndef EASED_TRANSITION_INTERPOLATOR_MACROS_SVH
`define EASED_TRANSITION_INTERPOLATOR_MACROS_SVH
// implication checked every clock outside reset
`define ETI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define ETI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: rtl/eti_pkg.sv
// shared constants and types for the eased transition interpolator
`timescale 1ns / 1ps
package eti_pkg;
  localparam int ValueWidthDef = 32;
  localparam int TimeWidthDef = 32;
  localparam int FracBitsDef = 16;
  localparam int ValueFracBits = 16;

  typedef enum logic [1:0] {
    EASE_LINEAR = 2'd0,
    EASE_IN     = 2'd1,
    EASE_DECEL  = 2'd2,
    EASE_SMOOTH = 2'd3
  } ease_kind_t;
endpackage

// File: rtl/eti_div_cell.sv
// one restoring step of the progress divider, registered
`timescale 1ns / 1ps
module eti_div_cell #(
  parameter int TW = 32,
  parameter int F = 16,
  parameter int VW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              v_in,
  input  logic [TW-1:0]     r_in,
  input  logic [TW-1:0]     d_in,
  input  logic [F:0]        q_in,
  input  logic              done_in,
  input  logic [1:0]        kind_in,
  input  logic [VW-1:0]     a_in,
  input  logic [VW-1:0]     b_in,
  input  logic              whole_in,
  output logic              v_out,
  output logic [TW-1:0]     r_out,
  output logic [TW-1:0]     d_out,
  output logic [F:0]        q_out,
  output logic              done_out,
  output logic [1:0]        kind_out,
  output logic [VW-1:0]     a_out,
  output logic [VW-1:0]     b_out,
  output logic              whole_out
);
  logic [TW-1:0] gap;
  logic          ge;
  assign gap = d_in - r_in;
  assign ge  = (r_in >= gap);

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (adv) begin
      v_out <= v_in;
    end
    if (adv) begin
      r_out     <= ge ? (r_in - gap) : (r_in + r_in);
      q_out     <= {q_in[F-1:0], ge};
      d_out     <= d_in;
      done_out  <= done_in;
      kind_out  <= kind_in;
      a_out     <= a_in;
      b_out     <= b_in;
      whole_out <= whole_in;
    end
  end
endmodule

// File: rtl/eti_back.sv
// easing, interpolation and whole-number rounding, four register stages
`timescale 1ns / 1ps
module eti_back #(
  parameter int F = 16,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          v_in,
  input  logic [F:0]    q_in,
  input  logic          done_in,
  input  logic [1:0]    kind_in,
  input  logic [VW-1:0] a_in,
  input  logic [VW-1:0] b_in,
  input  logic          whole_in,
  output logic          v_out,
  output logic [VW-1:0] val_out,
  output logic          done_out
);
  localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};
  localparam logic [F:0] HALF = {2'b01, {(F-1){1'b0}}};
  localparam int VF = eti_pkg::ValueFracBits;

  // stage 1: progress, square operand
  logic          v1, done1, whole1, sel1;
  logic [1:0]    kind1;
  logic [F:0]    p1;
  logic [VW-1:0] a1, b1;
  logic [F:0]    p;
  assign p = done_in ? ONE : q_in;

  // stage 2: eased progress and magnitude
  logic          v2, done2, whole2, up2;
  logic [F:0]    e2;
  logic [VW-1:0] a2;
  logic [VW:0]   mag2;

  // stage 3: product
  logic          v3, done3, whole3, up3;
  logic [VW-1:0] a3;
  logic [VW+F:0] prod3;

  logic [F:0]      x;
  logic [2*F+1:0]  sq;
  logic [F:0]      e;
  logic [VW:0]     sa, sb;
  logic [VW-1:0]   step, v, vw;
  logic [VW:0]     ssa, ssb;

  assign x = sel1 ? p1 : (ONE - p1);
  assign sq = x * x;
  always_comb begin
    unique case (eti_pkg::ease_kind_t'(kind1))
      eti_pkg::EASE_IN:     e = sq[2*F:F];
      eti_pkg::EASE_DECEL:  e = ONE - sq[2*F:F];
      eti_pkg::EASE_SMOOTH: e = (p1 < HALF) ? sq[2*F-1:F-1] : (ONE - sq[2*F-1:F-1]);
      default: e = p1;
    endcase
  end
  assign ssa = {a1[VW-1], a1};
  assign ssb = {b1[VW-1], b1};
  assign sa = ssa;
  assign sb = ssb;

  assign step = prod3[VW+F-1:F];
  assign v = up3 ? (a3 + step) : (a3 - step);
  always_comb begin
    if (v[VW-1] && (v[VF-1:0] != '0)) begin
      vw = {v[VW-1:VF], {VF{1'b0}}} + {{(VW-VF-1){1'b0}}, 1'b1, {VF{1'b0}}};
    end else begin
      vw = {v[VW-1:VF], {VF{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v_out <= 1'b0;
    end else if (adv) begin
      v1 <= v_in; v2 <= v1; v3 <= v2; v_out <= v3;
    end
    if (adv) begin
      p1 <= p; done1 <= done_in; whole1 <= whole_in; kind1 <= kind_in;
      a1 <= a_in; b1 <= b_in;
      sel1 <= (kind_in == eti_pkg::EASE_IN) ||
              ((kind_in == eti_pkg::EASE_SMOOTH) && (p < HALF));
      e2 <= e; done2 <= done1; whole2 <= whole1; a2 <= a1;
      up2 <= ($signed(sb) >= $signed(sa));
      mag2 <= ($signed(sb) >= $signed(sa)) ? (sb - sa) : (sa - sb);
      prod3 <= (VW+F+1)'(mag2 * e2);
      up3 <= up2; a3 <= a2; done3 <= done2; whole3 <= whole2;
      val_out <= whole3 ? vw : v;
      done_out <= done3;
    end
  end
endmodule

// File: rtl/eased_transition_interpolator.sv
// top level: pipelined eased interpolation, one divider cell per progress fraction bit
//
//  channel | signals                                   | direction
//  input   | in_valid in_stall + six item fields        | in
//  output  | out_valid out_stall current_value finished | out
//
// one item per cycle when the output is not stalled
// the path runs through one registered cell per progress fraction bit, then the four back stages
// the whole pipe advances together; a stalled output holds it and raises in_stall
// only when the final register is full and stalled
// synchronous reset empties every stage
`timescale 1ns / 1ps
module eased_transition_interpolator #(
  parameter int VALUE_WIDTH = eti_pkg::ValueWidthDef,
  parameter int TIME_WIDTH = eti_pkg::TimeWidthDef,
  parameter int PROGRESS_FRACTION_BITS = eti_pkg::FracBitsDef
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TIME_WIDTH-1:0]  elapsed_ticks,
  input  logic [TIME_WIDTH-1:0]  duration_ticks,
  input  logic [1:0]             easing_kind,
  input  logic signed [VALUE_WIDTH-1:0] start_value,
  input  logic signed [VALUE_WIDTH-1:0] end_value,
  input  logic                   whole_number_channel,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [VALUE_WIDTH-1:0] current_value,
  output logic                   finished
);
  localparam int F = PROGRESS_FRACTION_BITS;
  localparam int TW = TIME_WIDTH;
  localparam int VW = VALUE_WIDTH;
  localparam int N = F + 1;

  logic adv;
  // pipe moves whenever the last register is free or being taken
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic          cv [N];
  logic [TW-1:0] cr [N];
  logic [TW-1:0] cd [N];
  logic [F:0]    cq [N];
  logic          cdone [N];
  logic [1:0]    ck [N];
  logic [VW-1:0] ca [N];
  logic [VW-1:0] cb [N];
  logic          cw [N];

  assign cv[0] = in_valid;
  assign cd[0] = duration_ticks;
  assign cdone[0] = (elapsed_ticks >= duration_ticks);
  // a finished item feeds zero so the cells stay in range
  assign cr[0] = cdone[0] ? '0 : elapsed_ticks;
  assign cq[0] = '0;
  assign ck[0] = easing_kind;
  assign ca[0] = start_value;
  assign cb[0] = end_value;
  assign cw[0] = whole_number_channel;

  for (genvar i = 0; i < F; i++) begin : g_cell
    eti_div_cell #(.TW(TW), .F(F), .VW(VW)) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .v_in(cv[i]), .r_in(cr[i]), .d_in(cd[i]), .q_in(cq[i]),
      .done_in(cdone[i]), .kind_in(ck[i]), .a_in(ca[i]), .b_in(cb[i]),
      .whole_in(cw[i]),
      .v_out(cv[i+1]), .r_out(cr[i+1]), .d_out(cd[i+1]), .q_out(cq[i+1]),
      .done_out(cdone[i+1]), .kind_out(ck[i+1]), .a_out(ca[i+1]),
      .b_out(cb[i+1]), .whole_out(cw[i+1])
    );
  end

  logic [VW-1:0] val;
  eti_back #(.F(F), .VW(VW)) u_back (
    .clk(clk), .rst(rst), .adv(adv),
    .v_in(cv[F]), .q_in(cq[F]), .done_in(cdone[F]), .kind_in(ck[F]),
    .a_in(ca[F]), .b_in(cb[F]), .whole_in(cw[F]),
    .v_out(out_valid), .val_out(val), .done_out(finished)
  );
  assign current_value = val;

  logic [TW-1:0] unused_r;
  assign unused_r = cr[F];
endmodule

// File: rtl/eti_checker.sv
// port-level checker for the interpolator, bound to the top level
`timescale 1ns / 1ps
`include "eased_transition_interpolator_macros.svh"
module eti_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] current_value,
  input logic        finished
);
  `ETI_ASSERT_IMP(a_stall_only_when_blocked, in_stall, out_valid && out_stall)
  `ETI_ASSERT_NEXT(a_hold_value, out_valid && out_stall, $stable(current_value))
  `ETI_ASSERT_NEXT(a_hold_valid, out_valid && out_stall, out_valid && $stable(finished))
endmodule

bind eased_transition_interpolator eti_port_checker u_eti_port_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .current_value(32'(current_value)), .finished(finished)
);

// File: verif/eti_checker.sv
// checker: predicts each interpolation result and compares the output transfers
`timescale 1ns / 1ps
module eti_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [31:0]        elapsed_ticks,
  input  logic [31:0]        duration_ticks,
  input  logic [1:0]         easing_kind,
  input  logic signed [31:0] start_value,
  input  logic signed [31:0] end_value,
  input  logic               whole_number_channel,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] current_value,
  input  logic               finished,
  output int                 fail_count,
  output int                 pending_count
);
  localparam int FracBits = 16;
  localparam logic [63:0] ProgressOne = 64'd1 << FracBits;

  typedef struct packed {
    logic [31:0] value;
    logic        done;
  } eased_result_t;

  eased_result_t awaited_results[$];

  function automatic eased_result_t interpolate(input logic [31:0] elapsed,
      input logic [31:0] duration, input eti_pkg::ease_kind_t kind,
      input logic signed [31:0] a, input logic signed [31:0] b,
      input logic whole);
    eased_result_t r;
    logic [63:0] p, e, inv, mag, step, num;
    logic signed [63:0] v;
    r.done = elapsed >= duration;
    if (r.done) p = ProgressOne;
    else begin
      num = {32'd0, elapsed} << FracBits;
      p = num / {32'd0, duration};
    end
    inv = ProgressOne - p;
    case (kind)
      eti_pkg::EASE_IN: e = (p * p) >> FracBits;
      eti_pkg::EASE_DECEL: e = ProgressOne - ((inv * inv) >> FracBits);
      eti_pkg::EASE_SMOOTH: begin
        if (p < (ProgressOne >> 1)) e = (p * p) >> (FracBits - 1);
        else e = ProgressOne - ((inv * inv) >> (FracBits - 1));
      end
      default: e = p;
    endcase
    if (b >= a) begin
      mag = 64'(64'sd0 + b - a);
      step = (mag * e) >> FracBits;
      v = 64'sd0 + a + $signed(step);
    end else begin
      mag = 64'(64'sd0 + a - b);
      step = (mag * e) >> FracBits;
      v = 64'sd0 + a - $signed(step);
    end
    if (whole) begin
      if (v < 0 && v[15:0] != 0) v = {v[63:16], 16'd0} + 64'sd65536;
      else v = {v[63:16], 16'd0};
    end
    r.value = v[31:0];
    return r;
  endfunction

  assign pending_count = awaited_results.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    eased_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        awaited_results.push_back(interpolate(elapsed_ticks, duration_ticks,
            eti_pkg::ease_kind_t'(easing_kind), start_value, end_value,
            whole_number_channel));
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result value %h finished %b", $time,
              current_value, finished);
          fail_count <= fail_count + 1;
        end else begin
          want = awaited_results.pop_front();
          if (want.value !== current_value || want.done !== finished) begin
            $display("%0t: expected value %h finished %b, got value %h finished %b",
                $time, want.value, want.done, current_value, finished);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

// File: verif/testbench.sv
// testbench top: drives stimulus into the interpolator and gives the verdict
`timescale 1ns / 1ps
module testbench;
  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [31:0] elapsed_ticks, duration_ticks;
  logic [1:0] easing_kind;
  logic signed [31:0] start_value, end_value, current_value;
  logic whole_number_channel, finished;
  int fail_count, pending_count;
  int send_idle_pct, recv_stall_pct;
  int hold_cycles;
  longint cycle_count;

  eased_transition_interpolator i_dut (.*);

  eti_checker i_checker (.*);

  // free-running clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // watchdog on total cycles
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        hold_cycles--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // random 32-bit value biased toward edges
  function automatic logic [31:0] pick_word();
    case ($urandom_range(5))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return $urandom_range(4096);
      default: return $urandom;
    endcase
  endfunction

  // one transfer; waits out stall, holds payload until accepted
  task automatic send_item(input logic [31:0] el, input logic [31:0] du,
      input eti_pkg::ease_kind_t k, input logic [31:0] a, input logic [31:0] b,
      input logic w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    elapsed_ticks <= el;
    duration_ticks <= du;
    easing_kind <= k;
    start_value <= a;
    end_value <= b;
    whole_number_channel <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [31:0] du, el;
    du = pick_word();
    case ($urandom_range(3))
      0: el = du == 0 ? 0 : $urandom_range(du);
      1: el = du;
      2: el = pick_word();
      default: el = (du >> 1) + $urandom_range(3);
    endcase
    send_item(el, du, eti_pkg::ease_kind_t'($urandom_range(3)), pick_word(),
        pick_word(), 1'($urandom_range(1)));
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending_count != 0) @(negedge clk);
    repeat (30) @(negedge clk);
  endtask

  initial begin
    rst = 1;
    in_valid = 0;
    elapsed_ticks = 0;
    duration_ticks = 0;
    easing_kind = 0;
    start_value = 0;
    end_value = 0;
    whole_number_channel = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: each curve at start, middle and past end, plus zero duration
    for (int k = 0; k < 4; k++) begin
      send_item(0, 100, eti_pkg::ease_kind_t'(k), 32'h0001_0000, 32'hFFF0_8000, 0);
      send_item(50, 100, eti_pkg::ease_kind_t'(k), 32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_item(37, 100, eti_pkg::ease_kind_t'(k), 32'hFFFF_8001, 32'h0003_4000, 1);
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFE, eti_pkg::ease_kind_t'(k), 5, 9, 1);
      send_item(7, 0, eti_pkg::ease_kind_t'(k), 32'h7FFF_FFFF, 32'h8000_0000, 0);
    end
    // equal endpoints, then the full signed range just before the end
    send_item(3, 10, eti_pkg::EASE_SMOOTH, 32'h1234_5678, 32'h1234_5678, 0);
    send_item(32'hFFFF_FFFE, 32'hFFFF_FFFF, eti_pkg::EASE_DECEL, 32'h8000_0000,
        32'h7FFF_FFFF, 1);

    // random phases with different idling mixes
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1) ? 51 : (phase == 3) ? 32 : 0;
      recv_stall_pct = (phase == 2) ? 51 : (phase == 3) ? 32 : 0;
      for (int i = 0; i < 220; i++) send_random();
      if (phase == 0) begin
        // long receiver hold-off while items keep coming
        hold_cycles = 80;
        for (int i = 0; i < 40; i++) send_random();
      end
      // pause until every result is back
      drain();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// File: eased_transition_interpolator.f
+incdir+rtl
rtl/eti_pkg.sv
rtl/eti_div_cell.sv
rtl/eti_back.sv
rtl/eased_transition_interpolator.sv
rtl/eti_checker.sv
verif/eti_checker.sv
verif/testbench.sv
